FILE: sv/part21_record_lexer_unit_defines.svh
// ----------------------------------------------------------------------------
// part21 record lexer assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef PART21_RECORD_LEXER_UNIT_DEFINES_SVH
`define PART21_RECORD_LEXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define P21LEX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define P21LEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define P21LEX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define P21LEX_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/p21lex_pkg.sv
// ----------------------------------------------------------------------------
// p21lex_pkg
// Shared types, codes and constants of the part21 record lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package p21lex_pkg;

    // byte counter width and the width of its limit compare
    localparam int CountBits  = 40;
    localparam int LexedBits  = 40;
    localparam int CmpBits    = (CountBits > LexedBits) ? CountBits : LexedBits;

    // config port shape
    localparam int AddrBits   = 5;
    localparam int DataBits   = 64;

    // result queue shape
    localparam int QDepth     = 4;
    localparam int QPtrBits   = 2;
    localparam int QLevelBits = 3;
    localparam int MaxResults = 3;

    // register defaults
    localparam logic [LexedBits-1:0] DefMaxLexed  = {LexedBits{1'b1}};
    localparam logic [15:0]          DefMaxRecord = 16'hFFFF;
    localparam logic [15:0]          DefMaxString = 16'hFFFF;
    localparam logic [7:0]           DefMaxDepth  = 8'd64;

    // result kinds
    localparam logic [1:0] KindByte   = 2'd0;
    localparam logic [1:0] KindEnd    = 2'd1;
    localparam logic [1:0] KindStatus = 2'd2;

    // status codes
    localparam logic [2:0] StOk        = 3'd0;
    localparam logic [2:0] StEncoding  = 3'd1;
    localparam logic [2:0] StRecord    = 3'd2;
    localparam logic [2:0] StString    = 3'd3;
    localparam logic [2:0] StDepth     = 3'd4;
    localparam logic [2:0] StSource    = 3'd5;
    localparam logic [2:0] StMalformed = 3'd6;

    // characters
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChDquote = 8'h22;

    typedef struct packed {
        logic [LexedBits-1:0] max_lexed;
        logic [15:0]          max_record;
        logic [15:0]          max_string;
        logic [7:0]           max_depth;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic [8:0] max_depth_seen;
        logic       last;
    } t_result;

    // results of one request, in order; count is 1 to 3
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_push;

    typedef struct packed {
        logic [QLevelBits-1:0] level;
        logic                  room;
    } t_rq_stat;

endpackage

`default_nettype wire

FILE: sv/p21lex_cfg.sv
// ----------------------------------------------------------------------------
// p21lex_cfg
// Limit registers behind an APB-style port, 64-bit data at 8-byte spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module p21lex_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [p21lex_pkg::AddrBits-1:0]    paddr,
    input  wire logic [p21lex_pkg::DataBits-1:0]    pwdata,
    output logic      [p21lex_pkg::DataBits-1:0]    prdata,
    output logic                                    pready,
    output p21lex_pkg::t_cfg                        o_cfg
);

    localparam logic [1:0] RegMaxLexed  = 2'd0;
    localparam logic [1:0] RegMaxRecord = 2'd1;
    localparam logic [1:0] RegMaxString = 2'd2;
    localparam logic [1:0] RegMaxDepth  = 2'd3;

    logic [p21lex_pkg::LexedBits-1:0] r_max_lexed;
    logic [15:0]                      r_max_record;
    logic [15:0]                      r_max_string;
    logic [7:0]                       r_max_depth;
    logic [1:0]                       w_index;
    logic                             w_write;

    assign w_index = paddr[4:3];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lexed  <= p21lex_pkg::DefMaxLexed;
            r_max_record <= p21lex_pkg::DefMaxRecord;
            r_max_string <= p21lex_pkg::DefMaxString;
            r_max_depth  <= p21lex_pkg::DefMaxDepth;
        end else if (w_write) begin
            unique case (w_index)
                RegMaxLexed:  r_max_lexed  <= pwdata[p21lex_pkg::LexedBits-1:0];
                RegMaxRecord: r_max_record <= pwdata[15:0];
                RegMaxString: r_max_string <= pwdata[15:0];
                RegMaxDepth:  r_max_depth  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_index)
            RegMaxLexed:  prdata = p21lex_pkg::DataBits'(r_max_lexed);
            RegMaxRecord: prdata = p21lex_pkg::DataBits'(r_max_record);
            RegMaxString: prdata = p21lex_pkg::DataBits'(r_max_string);
            RegMaxDepth:  prdata = p21lex_pkg::DataBits'(r_max_depth);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.max_lexed  = r_max_lexed;
    assign o_cfg.max_record = r_max_record;
    assign o_cfg.max_string = r_max_string;
    assign o_cfg.max_depth  = r_max_depth;

endmodule

`default_nettype wire

FILE: sv/p21lex_step.sv
// ----------------------------------------------------------------------------
// p21lex_step
// Lexer state and the single-pass rule that turns one request into results.
// ----------------------------------------------------------------------------
`default_nettype none

module p21lex_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic              i_action,
    input  wire logic [7:0]        i_byte,
    input  p21lex_pkg::t_cfg       i_cfg,
    output p21lex_pkg::t_push      o_push,
    output logic [2:0]             o_fail_code
);

    localparam int CntW = p21lex_pkg::CountBits;
    localparam int CmpW = p21lex_pkg::CmpBits;

    logic            r_in_comment, n_in_comment;
    logic            r_slash_held, n_slash_held;
    logic            r_in_string,  n_in_string;
    logic            r_quote_held, n_quote_held;
    logic            r_quote_dbl,  n_quote_dbl;
    logic [8:0]      r_nest,       n_nest;
    logic [8:0]      r_deep,       n_deep;
    logic [16:0]     r_rec_len,    n_rec_len;
    logic [16:0]     r_str_len,    n_str_len;
    logic [CntW-1:0] r_bytes_seen, n_bytes_seen;
    logic [2:0]      r_fail,       n_fail;

    p21lex_pkg::t_result w_pre, w_fin, w_st;
    logic                w_pre_ok, w_fin_ok;

    // per-request rule
    always_comb begin : step_rule
        logic       go;
        logic       main_path;
        logic       pre_req;
        logic [7:0] pre_byte;
        logic       fin_req;
        logic       fin_end;
        logic       fin_str;
        logic [7:0] fin_byte;
        logic [7:0] qch;
        logic       enc_bad;

        n_in_comment = r_in_comment;
        n_slash_held = r_slash_held;
        n_in_string  = r_in_string;
        n_quote_held = r_quote_held;
        n_quote_dbl  = r_quote_dbl;
        n_nest       = r_nest;
        n_deep       = r_deep;
        n_rec_len    = r_rec_len;
        n_str_len    = r_str_len;
        n_bytes_seen = r_bytes_seen;
        n_fail       = r_fail;

        go        = 1'b0;
        main_path = 1'b0;
        pre_req   = 1'b0;
        pre_byte  = '0;
        fin_req   = 1'b0;
        fin_end   = 1'b0;
        fin_str   = 1'b0;
        fin_byte  = '0;
        w_pre_ok  = 1'b0;
        w_fin_ok  = 1'b0;
        w_pre     = '0;
        w_fin     = '0;
        w_st      = '0;

        qch     = r_quote_dbl ? p21lex_pkg::ChDquote : p21lex_pkg::ChSquote;
        enc_bad = ((i_byte < p21lex_pkg::ChSpace) &&
                   !((i_byte >= p21lex_pkg::ChTab) && (i_byte <= p21lex_pkg::ChCr)))
                  || i_byte[7];

        if (r_fail == p21lex_pkg::StOk) begin
            if (i_action) begin
                // end-of-stream check
                if (r_in_string || r_in_comment || r_slash_held || r_quote_held ||
                    (r_nest != '0)) begin
                    n_fail = p21lex_pkg::StMalformed;
                end else if (r_rec_len != '0) begin
                    n_rec_len = '0;
                    n_str_len = '0;
                    fin_end   = 1'b1;
                end
            end else if ((CmpW'(r_bytes_seen) >= CmpW'(i_cfg.max_lexed)) ||
                         (&r_bytes_seen)) begin
                n_fail = p21lex_pkg::StSource;
            end else begin
                n_bytes_seen = r_bytes_seen + CntW'(1);
                if (r_in_comment) begin
                    // comment body, look for star then slash
                    if (r_slash_held && (i_byte == p21lex_pkg::ChSlash)) begin
                        n_in_comment = 1'b0;
                        n_slash_held = 1'b0;
                    end else begin
                        n_slash_held = (i_byte == p21lex_pkg::ChStar);
                    end
                end else begin
                    go = !r_in_string;
                    // string body and pending closing quote
                    if (r_in_string) begin
                        if (r_quote_held) begin
                            if (i_byte == qch) begin
                                n_quote_held = 1'b0;
                                fin_req      = 1'b1;
                                fin_byte     = i_byte;
                                fin_str      = 1'b1;
                            end else begin
                                pre_req      = 1'b1;
                                pre_byte     = qch;
                                n_quote_held = 1'b0;
                                n_in_string  = 1'b0;
                                go           = 1'b1;
                            end
                        end else if (i_byte == qch) begin
                            n_quote_held = 1'b1;
                        end else begin
                            fin_req  = 1'b1;
                            fin_byte = i_byte;
                            fin_str  = 1'b1;
                        end
                    end
                    // slash handling outside strings
                    if (go) begin
                        main_path = 1'b1;
                        if (i_byte == p21lex_pkg::ChSlash) begin
                            if (r_slash_held) begin
                                n_slash_held = 1'b0;
                                pre_req      = 1'b1;
                                pre_byte     = p21lex_pkg::ChSlash;
                            end else begin
                                n_slash_held = 1'b1;
                                main_path    = 1'b0;
                            end
                        end else if (r_slash_held) begin
                            n_slash_held = 1'b0;
                            if (i_byte == p21lex_pkg::ChStar) begin
                                n_in_comment = 1'b1;
                                main_path    = 1'b0;
                            end else begin
                                pre_req  = 1'b1;
                                pre_byte = p21lex_pkg::ChSlash;
                            end
                        end
                    end
                    // first emitted byte: held quote or held slash
                    if (pre_req) begin
                        if (r_rec_len >= {1'b0, i_cfg.max_record}) begin
                            n_fail    = p21lex_pkg::StRecord;
                            main_path = 1'b0;
                        end else begin
                            n_rec_len            = r_rec_len + 17'd1;
                            w_pre_ok             = 1'b1;
                            w_pre.kind           = p21lex_pkg::KindByte;
                            w_pre.out_byte       = pre_byte;
                            w_pre.status         = p21lex_pkg::StOk;
                            w_pre.max_depth_seen = r_deep;
                        end
                    end
                    // the byte itself outside strings
                    if (main_path) begin
                        if (enc_bad) begin
                            n_fail = p21lex_pkg::StEncoding;
                        end else if ((i_byte == p21lex_pkg::ChSquote) ||
                                     (i_byte == p21lex_pkg::ChDquote)) begin
                            n_in_string = 1'b1;
                            n_quote_dbl = (i_byte == p21lex_pkg::ChDquote);
                            n_str_len   = '0;
                            fin_req     = 1'b1;
                            fin_byte    = i_byte;
                        end else if (i_byte == p21lex_pkg::ChLParen) begin
                            if (r_nest != 9'h1FF) begin
                                n_nest = r_nest + 9'd1;
                            end
                            if (n_nest > r_deep) begin
                                n_deep = n_nest;
                            end
                            if (n_nest > {1'b0, i_cfg.max_depth}) begin
                                n_fail = p21lex_pkg::StDepth;
                            end else begin
                                fin_req  = 1'b1;
                                fin_byte = i_byte;
                            end
                        end else if (i_byte == p21lex_pkg::ChRParen) begin
                            if (r_nest != '0) begin
                                n_nest = r_nest - 9'd1;
                            end
                            fin_req  = 1'b1;
                            fin_byte = i_byte;
                        end else if ((i_byte == p21lex_pkg::ChSemi) && (r_nest == '0)) begin
                            n_rec_len = '0;
                            n_str_len = '0;
                            fin_end   = 1'b1;
                        end else begin
                            fin_req  = 1'b1;
                            fin_byte = i_byte;
                        end
                    end
                end
            end
        end

        // last emitted byte, with string length check
        if (fin_req) begin
            if (n_rec_len >= {1'b0, i_cfg.max_record}) begin
                n_fail = p21lex_pkg::StRecord;
            end else begin
                n_rec_len            = n_rec_len + 17'd1;
                w_fin_ok             = 1'b1;
                w_fin.kind           = p21lex_pkg::KindByte;
                w_fin.out_byte       = fin_byte;
                w_fin.status         = p21lex_pkg::StOk;
                w_fin.max_depth_seen = n_deep;
                if (fin_str) begin
                    n_str_len = r_str_len + 17'd1;
                    if (n_str_len > {1'b0, i_cfg.max_string}) begin
                        n_fail = p21lex_pkg::StString;
                    end
                end
            end
        end

        // record end marker
        if (fin_end) begin
            w_fin_ok             = 1'b1;
            w_fin.kind           = p21lex_pkg::KindEnd;
            w_fin.out_byte       = '0;
            w_fin.status         = p21lex_pkg::StOk;
            w_fin.max_depth_seen = n_deep;
        end

        // closing status result
        w_st.kind           = p21lex_pkg::KindStatus;
        w_st.out_byte       = '0;
        w_st.status         = n_fail;
        w_st.max_depth_seen = n_deep;
        w_st.last           = 1'b1;
    end

    // pack results in order
    always_comb begin
        o_push.r0 = w_st;
        o_push.r1 = w_st;
        o_push.r2 = w_st;
        if (w_pre_ok && w_fin_ok) begin
            o_push.count = 2'd3;
            o_push.r0    = w_pre;
            o_push.r1    = w_fin;
        end else if (w_pre_ok) begin
            o_push.count = 2'd2;
            o_push.r0    = w_pre;
        end else if (w_fin_ok) begin
            o_push.count = 2'd2;
            o_push.r0    = w_fin;
        end else begin
            o_push.count = 2'd1;
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_slash_held <= 1'b0;
            r_in_string  <= 1'b0;
            r_quote_held <= 1'b0;
            r_quote_dbl  <= 1'b0;
            r_nest       <= '0;
            r_deep       <= '0;
            r_rec_len    <= '0;
            r_str_len    <= '0;
            r_bytes_seen <= '0;
            r_fail       <= p21lex_pkg::StOk;
        end else if (i_advance) begin
            r_in_comment <= n_in_comment;
            r_slash_held <= n_slash_held;
            r_in_string  <= n_in_string;
            r_quote_held <= n_quote_held;
            r_quote_dbl  <= n_quote_dbl;
            r_nest       <= n_nest;
            r_deep       <= n_deep;
            r_rec_len    <= n_rec_len;
            r_str_len    <= n_str_len;
            r_bytes_seen <= n_bytes_seen;
            r_fail       <= n_fail;
        end
    end

    assign o_fail_code = r_fail;

endmodule

`default_nettype wire

FILE: sv/p21lex_rq.sv
// ----------------------------------------------------------------------------
// p21lex_rq
// Four-entry result queue: takes up to three results at once, sends one.
// ----------------------------------------------------------------------------
`default_nettype none

module p21lex_rq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_en,
    input  p21lex_pkg::t_push      i_push,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output p21lex_pkg::t_result    o_result,
    output p21lex_pkg::t_rq_stat   o_stat
);

    localparam int PtrW = p21lex_pkg::QPtrBits;
    localparam int LvlW = p21lex_pkg::QLevelBits;

    p21lex_pkg::t_result r_entry [p21lex_pkg::QDepth];
    p21lex_pkg::t_result w_slot  [p21lex_pkg::MaxResults];
    logic [PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [LvlW-1:0]     r_level,  n_level;
    logic [LvlW-1:0]     w_after_pop;
    logic                w_pop;

    assign w_slot[0] = i_push.r0;
    assign w_slot[1] = i_push.r1;
    assign w_slot[2] = i_push.r2;

    assign o_valid     = (r_level != '0);
    assign o_result    = r_entry[r_rd_ptr];
    assign w_pop       = o_valid && !i_stall;
    assign w_after_pop = r_level - LvlW'(w_pop);

    // room for a full set of results after this cycle's pop
    assign o_stat.room  = (w_after_pop <= LvlW'(p21lex_pkg::QDepth - p21lex_pkg::MaxResults));
    assign o_stat.level = r_level;

    // pointer and level update
    always_comb begin
        n_rd_ptr = r_rd_ptr + PtrW'(w_pop);
        n_wr_ptr = r_wr_ptr;
        n_level  = w_after_pop;
        if (i_push_en) begin
            n_wr_ptr = r_wr_ptr + PtrW'(i_push.count);
            n_level  = w_after_pop + LvlW'(i_push.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // entry writes, consecutive slots from the write pointer
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < p21lex_pkg::MaxResults; k++) begin
            if (i_push_en && (k < int'(i_push.count))) begin
                r_entry[PtrW'(r_wr_ptr + PtrW'(k))] <= w_slot[k];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/part21_record_lexer_unit.sv
// result path: input register, then the result queue, which offers the results
// throughput: one request per cycle while the queue has room; each request gives 1 to 3
//   results, the output sends one per cycle unless stalled, and the result count sets the pace
// reset: synchronous, active low; clears the lexer state, the failure code and
//   the result queue, and returns the limit registers to their defaults
// ----------------------------------------------------------------------------
// part21_record_lexer_unit
// Clear-text record lexer: input register, single-pass rule, result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "part21_record_lexer_unit_defines.svh"

module part21_record_lexer_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic [7:0]                         i_byte_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_kind,
    output logic [7:0]                              o_out_byte,
    output logic [2:0]                              o_status,
    output logic [8:0]                              o_max_depth_seen,
    output logic                                    o_last,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [p21lex_pkg::AddrBits-1:0]    paddr,
    input  wire logic [p21lex_pkg::DataBits-1:0]    pwdata,
    output logic      [p21lex_pkg::DataBits-1:0]    prdata,
    output logic                                    pready
);

    logic                  r_in_valid;
    logic                  r_in_action;
    logic [7:0]            r_in_byte;
    logic                  w_accept;
    logic                  w_advance;
    logic [2:0]            w_fail_code;
    p21lex_pkg::t_cfg      w_cfg;
    p21lex_pkg::t_push     w_push;
    p21lex_pkg::t_result   w_result;
    p21lex_pkg::t_rq_stat  w_rq_stat;

    // input register handshake
    assign w_advance  = r_in_valid && w_rq_stat.room;
    assign o_in_stall = r_in_valid && !w_rq_stat.room;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= i_action;
            r_in_byte   <= i_byte_value;
        end
    end

    // limit registers
    p21lex_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // lexer rule and state
    p21lex_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_action    (r_in_action),
        .i_byte      (r_in_byte),
        .i_cfg       (w_cfg),
        .o_push      (w_push),
        .o_fail_code (w_fail_code)
    );

    // result queue
    p21lex_rq u_rq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_advance),
        .i_push    (w_push),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (w_result),
        .o_stat    (w_rq_stat)
    );

    assign o_kind           = w_result.kind;
    assign o_out_byte       = w_result.out_byte;
    assign o_status         = w_result.status;
    assign o_max_depth_seen = w_result.max_depth_seen;
    assign o_last           = w_result.last;

    // checks
    `P21LEX_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, w_advance, o_out_valid)
    `P21LEX_ASSERT_NEXT(a_fail_sticky, i_clk, i_rst_n, (w_fail_code != p21lex_pkg::StOk), (w_fail_code == $past(w_fail_code)))
    `P21LEX_ASSERT_IMPL(a_stall_only_when_held, i_clk, i_rst_n, o_in_stall, r_in_valid)
    `P21LEX_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, (w_rq_stat.level <= 3'(p21lex_pkg::QDepth)))

endmodule

`default_nettype wire

FILE: verif/part21_record_lexer_checker.sv
// ----------------------------------------------------------------------------
// part21 record lexer checker
// Watches the request, result and register channels of the lexer, keeps its
// own copy of the lexer state and limits, and compares every result with the
// predicted one, field by field, in order.
// ----------------------------------------------------------------------------

// register map shared by the checker and the testbench top
package p21lex_regs_pkg;
    localparam int RegStride    = 8;
    localparam int RegMaxLexed  = 0;
    localparam int RegMaxRecord = 1;
    localparam int RegMaxString = 2;
    localparam int RegMaxDepth  = 3;
endpackage

module part21_record_lexer_checker
    import p21lex_pkg::*;
    import p21lex_regs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_action,
    input  logic [7:0]          i_byte_value,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_out_byte,
    input  logic [2:0]          i_status,
    input  logic [8:0]          i_max_depth_seen,
    input  logic                i_last,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [AddrBits-1:0] i_paddr,
    input  logic [DataBits-1:0] i_pwdata,
    input  logic                i_end_check,
    output int                  o_fail_count,
    output int                  o_outstanding
);

    // limit registers as the lexer should hold them
    logic [LexedBits-1:0] lim_lexed;
    logic [15:0]          lim_record;
    logic [15:0]          lim_string;
    logic [7:0]           lim_depth;

    // lexer state copy
    logic                 cmt_open;
    logic                 pend_mark;
    logic                 str_open;
    logic                 close_pending;
    logic                 str_dq;
    logic [8:0]           depth;
    logic [8:0]           depth_peak;
    logic [16:0]          rec_len;
    logic [16:0]          str_len;
    logic [CountBits-1:0] lexed;
    logic [2:0]           fail_st;

    // results of the request being lexed, and all results still owed
    t_result              step_buf[$];
    t_result              want_q[$];
    bit                   end_seen;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_fail_count < 40)
            $display("lexer mismatch: %s got %0h want %0h", what, got, want);
        o_fail_count++;
    endtask

    function automatic void put_result(input logic [1:0] kind, input logic [7:0] b);
        t_result r;
        if (step_buf.size() < MaxResults) begin
            r.kind           = kind;
            r.out_byte       = (kind == KindByte) ? b : 8'd0;
            r.status         = fail_st;
            r.max_depth_seen = depth_peak;
            r.last           = 1'b0;
            step_buf.push_back(r);
        end
    endfunction

    // first failure wins
    function automatic void set_fail(input logic [2:0] code);
        if (fail_st == StOk)
            fail_st = code;
    endfunction

    // record byte out, unless the record limit stops it
    function automatic bit emit_byte(input logic [7:0] b);
        if (rec_len >= {1'b0, lim_record}) begin
            set_fail(StRecord);
            return 1'b0;
        end
        rec_len++;
        put_result(KindByte, b);
        return 1'b1;
    endfunction

    function automatic void bump_string();
        str_len++;
        if (str_len > {1'b0, lim_string})
            set_fail(StString);
    endfunction

    function automatic void lex_one(input logic [7:0] c);
        logic [7:0] q;
        // inside a comment only a star-slash matters
        if (cmt_open) begin
            if (pend_mark && c == ChSlash) begin
                cmt_open  = 1'b0;
                pend_mark = 1'b0;
                return;
            end
            pend_mark = (c == ChStar);
            return;
        end
        // string body, with a doubled quote folded into one
        if (str_open) begin
            q = str_dq ? ChDquote : ChSquote;
            if (close_pending) begin
                if (c == q) begin
                    close_pending = 1'b0;
                    if (!emit_byte(c))
                        return;
                    bump_string();
                    return;
                end
                if (!emit_byte(q))
                    return;
                close_pending = 1'b0;
                str_open      = 1'b0;
            end else if (c == q) begin
                close_pending = 1'b1;
                return;
            end else begin
                if (!emit_byte(c))
                    return;
                bump_string();
                return;
            end
        end
        // held slash: comment opener, double slash or plain slash
        if (c == ChSlash) begin
            if (pend_mark) begin
                pend_mark = 1'b0;
                if (!emit_byte(ChSlash))
                    return;
            end else begin
                pend_mark = 1'b1;
                return;
            end
        end else if (pend_mark) begin
            pend_mark = 1'b0;
            if (c == ChStar) begin
                cmt_open = 1'b1;
                return;
            end
            if (!emit_byte(ChSlash))
                return;
        end
        // control and high bytes
        if ((c < ChSpace && !(c >= ChTab && c <= ChCr)) || c[7]) begin
            set_fail(StEncoding);
            return;
        end
        if (c == ChSquote || c == ChDquote) begin
            str_open = 1'b1;
            str_dq   = (c == ChDquote);
            str_len  = '0;
            void'(emit_byte(c));
            return;
        end
        // nesting and record end
        if (c == ChLParen) begin
            if (depth != 9'h1FF)
                depth++;
            if (depth > depth_peak)
                depth_peak = depth;
            if (depth > {1'b0, lim_depth}) begin
                set_fail(StDepth);
                return;
            end
        end else if (c == ChRParen) begin
            if (depth != 9'd0)
                depth--;
        end else if (c == ChSemi && depth == 9'd0) begin
            rec_len = '0;
            str_len = '0;
            put_result(KindEnd, 8'd0);
            return;
        end
        void'(emit_byte(c));
    endfunction

    function automatic void finish_stream();
        if (str_open || cmt_open || pend_mark || close_pending || depth != 9'd0) begin
            set_fail(StMalformed);
            return;
        end
        if (rec_len != '0) begin
            rec_len = '0;
            str_len = '0;
            put_result(KindEnd, 8'd0);
        end
    endfunction

    // results owed for one accepted request
    function automatic void predict_request(input logic act, input logic [7:0] c);
        t_result r;
        step_buf.delete();
        if (fail_st == StOk) begin
            if (act)
                finish_stream();
            else if (lexed >= lim_lexed || &lexed)
                set_fail(StSource);
            else begin
                lexed = lexed + 1'b1;
                lex_one(c);
            end
        end
        put_result(KindStatus, 8'd0);
        r = step_buf.pop_back();
        r.last = 1'b1;
        step_buf.push_back(r);
        foreach (step_buf[i])
            want_q.push_back(step_buf[i]);
    endfunction

    function automatic void write_limit(input logic [AddrBits-1:0] addr,
                                        input logic [DataBits-1:0] data);
        case (int'(addr) / RegStride)
            RegMaxLexed:  lim_lexed  = data[LexedBits-1:0];
            RegMaxRecord: lim_record = data[15:0];
            RegMaxString: lim_string = data[15:0];
            RegMaxDepth:  lim_depth  = data[7:0];
            default: ;
        endcase
    endfunction

    task automatic check_result();
        t_result want;
        if (want_q.size() == 0) begin
            report_mismatch("result with no request pending, kind", i_kind, 16'd0);
            return;
        end
        want = want_q.pop_front();
        if (i_kind != want.kind)
            report_mismatch("kind", i_kind, want.kind);
        if (i_out_byte != want.out_byte)
            report_mismatch("out_byte", i_out_byte, want.out_byte);
        if (i_status != want.status)
            report_mismatch("status", i_status, want.status);
        if (i_max_depth_seen != want.max_depth_seen)
            report_mismatch("max_depth_seen", i_max_depth_seen, want.max_depth_seen);
        if (i_last != want.last)
            report_mismatch("last", i_last, want.last);
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_lexed     = DefMaxLexed;
            lim_record    = DefMaxRecord;
            lim_string    = DefMaxString;
            lim_depth     = DefMaxDepth;
            cmt_open      = 1'b0;
            pend_mark     = 1'b0;
            str_open      = 1'b0;
            close_pending = 1'b0;
            str_dq        = 1'b0;
            depth         = '0;
            depth_peak    = '0;
            rec_len       = '0;
            str_len       = '0;
            lexed         = '0;
            fail_st       = StOk;
            want_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                predict_request(i_action, i_byte_value);
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_limit(i_paddr, i_pwdata);
            // results still owed once the run has drained
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (want_q.size() != 0)
                    report_mismatch("results never delivered", 16'd0, 16'(want_q.size()));
            end
        end
        o_outstanding = want_q.size();
    end

endmodule

FILE: verif/tb_part21_record_lexer_unit.sv
// ----------------------------------------------------------------------------
// tb_part21_record_lexer_unit
// Drives byte and finish requests into the record lexer: a short directed
// stream of comments, strings, slashes and nesting, then random well-formed
// records under several limit settings with bursty requests and a stalling
// receiver, and finally one provoked failure followed by random noise.
// ----------------------------------------------------------------------------
module tb_part21_record_lexer_unit
    import p21lex_pkg::*;
    import p21lex_regs_pkg::*;
;

    localparam int Timeout      = 1000000;
    localparam int SettleCycles = 8;

    // block ports
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_action;
    logic [7:0]          i_byte_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_kind;
    logic [7:0]          o_out_byte;
    logic [2:0]          o_status;
    logic [8:0]          o_max_depth_seen;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrBits-1:0] paddr;
    logic [DataBits-1:0] pwdata;
    logic [DataBits-1:0] prdata;
    logic                pready;

    // checker hookup
    logic                end_check;
    int                  fail_count;
    int                  outstanding;

    // sender and receiver shaping
    int unsigned         gap_max;
    int unsigned         burst_max;
    int unsigned         burst_left;
    int unsigned         stall_pct;
    bit                  pressure_on;
    int unsigned         long_holds;

    // request bookkeeping and the limits the generator respects
    int unsigned         sent_count;
    longint unsigned     lexed_total;
    int unsigned         cur_record;
    int unsigned         cur_string;
    int unsigned         cur_depth;

    part21_record_lexer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_byte_value     (i_byte_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_out_byte       (o_out_byte),
        .o_status         (o_status),
        .o_max_depth_seen (o_max_depth_seen),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    part21_record_lexer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_byte_value     (i_byte_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_kind           (o_kind),
        .i_out_byte       (o_out_byte),
        .i_status         (o_status),
        .i_max_depth_seen (o_max_depth_seen),
        .i_last           (o_last),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_end_check      (end_check),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #(Timeout);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stall pattern, with long hold-offs while pressure is on
    initial begin : receiver
        int unsigned hold_left;
        hold_left   = 0;
        long_holds  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (pressure_on && (long_holds == 0 || $urandom_range(0, 299) == 0)) begin
                hold_left = $urandom_range(60, 100);
                long_holds++;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
        end
    end

    // one request, offered in bursts with random gaps, held until taken
    task automatic send_req(input logic act, input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid   <= 1'b0;
                i_action     <= 1'($urandom);
                i_byte_value <= 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent_count++;
        if (!act)
            lexed_total++;
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_req(1'b0, txt[i]);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait (outstanding == 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input int idx, input logic [DataBits-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrBits'(idx * RegStride);
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [DataBits-1:0] lexed_lim, input int unsigned rec,
                              input int unsigned str, input int unsigned dep);
        write_reg(RegMaxLexed, lexed_lim);
        write_reg(RegMaxRecord, DataBits'(rec));
        write_reg(RegMaxString, DataBits'(str));
        write_reg(RegMaxDepth, DataBits'(dep));
        cur_record = rec;
        cur_string = str;
        cur_depth  = dep;
    endtask

    // a byte that the lexer passes through as a plain record byte
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0:       b = 8'($urandom_range(9, 13));
            1:       b = 8'h7F;
            default: b = 8'($urandom_range(32, 126));
        endcase
        if (b == ChSlash || b == ChLParen || b == ChRParen || b == ChSemi ||
            b == ChSquote || b == ChDquote)
            b = 8'h2E;
        return b;
    endfunction

    function automatic bit fits(input int unsigned rec, input int unsigned dep,
                                input int unsigned k);
        return rec + dep + k <= cur_record;
    endfunction

    // one well-formed record with random content, kept inside the limits
    task automatic send_record();
        int unsigned rec, dep, tokens, n, n_max, i, j;
        logic [7:0]  q, b;
        bit          star;
        rec    = 0;
        dep    = 0;
        tokens = $urandom_range(1, 12);
        for (i = 0; i < tokens; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if (fits(rec, dep, 1)) begin
                        send_req(1'b0, plain_byte());
                        rec++;
                    end
                end
                3: begin
                    if (dep < cur_depth && fits(rec, dep, 2)) begin
                        send_req(1'b0, ChLParen);
                        rec++;
                        dep++;
                    end
                end
                4: begin
                    // closing paren, also stray ones at depth zero
                    if (fits(rec, dep, 1)) begin
                        send_req(1'b0, ChRParen);
                        rec++;
                        if (dep != 0)
                            dep--;
                    end
                end
                5: begin
                    // comment with arbitrary bytes that never close it early
                    send_req(1'b0, ChSlash);
                    send_req(1'b0, ChStar);
                    star = 1'b0;
                    n    = $urandom_range(0, 6);
                    for (j = 0; j < n; j++) begin
                        b = 8'($urandom);
                        if (star && b == ChSlash)
                            b = ChStar;
                        star = (b == ChStar);
                        send_req(1'b0, b);
                    end
                    send_req(1'b0, ChStar);
                    send_req(1'b0, ChSlash);
                end
                6: begin
                    // double slash or a lone slash before a plain byte
                    if (fits(rec, dep, 2)) begin
                        send_req(1'b0, ChSlash);
                        if ($urandom_range(0, 1) == 0) begin
                            send_req(1'b0, ChSlash);
                        end else begin
                            b = plain_byte();
                            if (b == ChStar)
                                b = 8'h2E;
                            send_req(1'b0, b);
                        end
                        rec += 2;
                    end
                end
                7, 8: begin
                    // quoted string with doubled quotes and any other byte
                    n_max = (cur_string < 6) ? cur_string : 6;
                    n     = $urandom_range(0, n_max);
                    if (fits(rec, dep, n + 3)) begin
                        q = ($urandom_range(0, 1) == 0) ? ChSquote : ChDquote;
                        send_req(1'b0, q);
                        for (j = 0; j < n; j++) begin
                            if ($urandom_range(0, 4) == 0) begin
                                send_req(1'b0, q);
                                send_req(1'b0, q);
                            end else begin
                                b = 8'($urandom);
                                if (b == q)
                                    b = q ^ 8'h01;
                                send_req(1'b0, b);
                            end
                        end
                        send_req(1'b0, q);
                        send_req(1'b0, plain_byte());
                        rec += n + 3;
                    end
                end
                default: begin
                    // semicolon inside parens is a plain byte
                    if (dep != 0 && fits(rec, dep, 1)) begin
                        send_req(1'b0, ChSemi);
                        rec++;
                    end
                end
            endcase
        end
        while (dep != 0) begin
            send_req(1'b0, ChRParen);
            dep--;
        end
        // record end by semicolon or by end-of-stream check
        if (rec != 0 && $urandom_range(0, 3) == 0)
            send_req(1'b1, 8'($urandom));
        else
            send_req(1'b0, ChSemi);
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned stop_at;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                send_req(1'b1, 8'($urandom));
            else
                send_record();
        end
    endtask

    // one sticky failure, then random requests that must only report it
    task automatic provoke_failure();
        int unsigned k, i;
        logic [7:0]  b;
        drain();
        case ($urandom_range(0, 5))
            0: begin
                if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(128, 255));
                else if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(0, 8));
                else
                    b = 8'($urandom_range(14, 31));
                send_req(1'b0, b);
            end
            1: begin
                k = $urandom_range(1, 4);
                write_reg(RegMaxRecord, DataBits'(k));
                for (i = 0; i <= k; i++)
                    send_req(1'b0, plain_byte());
            end
            2: begin
                k = $urandom_range(0, 3);
                write_reg(RegMaxString, DataBits'(k));
                send_req(1'b0, ChDquote);
                for (i = 0; i <= k; i++)
                    send_req(1'b0, 8'($urandom_range(35, 255)));
            end
            3: begin
                k = $urandom_range(0, 3);
                write_reg(RegMaxDepth, DataBits'(k));
                for (i = 0; i <= k; i++)
                    send_req(1'b0, ChLParen);
            end
            4: begin
                k = $urandom_range(0, 3);
                write_reg(RegMaxLexed, DataBits'(lexed_total + k));
                for (i = 0; i <= k; i++)
                    send_req(1'b0, plain_byte());
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: send_req(1'b0, ChSquote);
                    1: send_req(1'b0, ChLParen);
                    2: send_text("/*");
                    default: send_req(1'b0, ChSlash);
                endcase
                send_req(1'b1, 8'($urandom));
            end
        endcase
        for (i = 0; i < 20; i++)
            send_req(1'($urandom), 8'($urandom));
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = 1'b0;
        i_byte_value = 8'd0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        end_check    = 1'b0;
        gap_max      = 0;
        burst_max    = 8;
        burst_left   = 0;
        stall_pct    = 0;
        pressure_on  = 1'b0;
        sent_count   = 0;
        lexed_total  = 0;
        cur_record   = DefMaxRecord;
        cur_string   = DefMaxString;
        cur_depth    = DefMaxDepth;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty finish, comment with odd bytes, double slash,
        // doubled quote, nesting, stray paren, lone slash, finish-ended record
        send_req(1'b1, 8'hA5);
        send_text("/*");
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        send_text("*/B//C'x''");
        send_req(1'b0, 8'h80);
        send_text("'(\"q\"));");
        send_text("/a");
        send_req(1'b1, 8'h00);
        drain();

        // widest limits
        stall_pct = 30;
        gap_max   = 3;
        burst_max = 6;
        set_limits({LexedBits{1'b1}}, 65535, 65535, 255);
        run_phase(80);
        drain();

        // no bytes allowed: only end-of-stream checks
        write_reg(RegMaxLexed, '0);
        repeat (5) send_req(1'b1, 8'($urandom));
        drain();

        // tightest limits, no idling on either side
        stall_pct = 0;
        gap_max   = 0;
        burst_max = 20;
        set_limits({$urandom_range(1, 255), 32'($urandom)}, 1, 0, 0);
        run_phase(40);
        drain();

        // small limits, heavy idling
        stall_pct = 50;
        gap_max   = 6;
        burst_max = 3;
        set_limits({LexedBits{1'b1}}, $urandom_range(12, 60), $urandom_range(0, 8),
                   $urandom_range(1, 4));
        run_phase(110);
        drain();

        // medium limits with long receiver hold-offs
        stall_pct   = 20;
        gap_max     = 2;
        burst_max   = 10;
        pressure_on = 1'b1;
        set_limits({LexedBits{1'b1}}, $urandom_range(150, 400), $urandom_range(8, 40),
                   $urandom_range(5, 16));
        run_phase(100);
        pressure_on = 1'b0;

        stall_pct = 40;
        gap_max   = 4;
        burst_max = 5;
        provoke_failure();
        drain();

        end_check <= 1'b1;
        repeat (3) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/p21lex_pkg.sv
sv/p21lex_cfg.sv
sv/p21lex_step.sv
sv/p21lex_rq.sv
sv/part21_record_lexer_unit.sv
verif/part21_record_lexer_checker.sv
verif/tb_part21_record_lexer_unit.sv
